>>> hw/rtl/rrtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrtt_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int LIVE_W     = $clog2(SLOT_COUNT + 1);

  localparam int MODE_W       = 3;
  localparam int ID_W         = 32;
  localparam int STATUS_W     = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int LIVE_FIELD_W = 5;

  localparam logic [MODE_W-1:0] MODE_CREATE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TERMINATE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLOCK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNBLOCK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [ID_W-1:0] ID_FIRST = 32'd1;
  localparam logic [ID_W-1:0] ID_NEXT  = 32'd2;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_BLOCKED = 2'd3
  } slot_state_t;

  typedef struct packed {
    slot_state_t     state;
    logic [ID_W-1:0] id;
  } slot_word_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_word_t        word;
  } slot_wr_t;

  localparam slot_word_t SLOT0_RESET = '{state: SLOT_READY, id: ID_FIRST};
  localparam slot_word_t SLOTN_RESET = '{state: SLOT_FREE, id: '0};

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rrtt_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrtt_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [rrtt_pkg::MODE_W-1:0]      mode;
  logic [rrtt_pkg::ID_W-1:0]        target_id;

  modport source (output valid, mode, target_id, input ready);
  modport sink   (input valid, mode, target_id, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rrtt_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrtt_res_if;
  logic                                valid;
  logic                                ready;
  logic [rrtt_pkg::STATUS_W-1:0]       status;
  logic [rrtt_pkg::ID_W-1:0]           new_id;
  logic [rrtt_pkg::SLOT_FIELD_W-1:0]   running_slot;
  logic                                switched;
  logic [rrtt_pkg::LIVE_FIELD_W-1:0]   live_threads;

  modport source (output valid, status, new_id, running_slot, switched, live_threads,
                  input ready);
  modport sink   (input valid, status, new_id, running_slot, switched, live_threads,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rrtt_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none

module rrtt_slot_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rrtt_pkg::SLOT_W-1:0]   rd_addr,
  output rrtt_pkg::slot_word_t               rd_word,
  input  wire rrtt_pkg::slot_wr_t            wr
);

  rrtt_pkg::slot_word_t                  mem [rrtt_pkg::SLOT_COUNT];
  logic [rrtt_pkg::SLOT_COUNT-1:0]       valid;
  rrtt_pkg::slot_word_t                  rd_q;
  logic                                  rd_valid;
  logic                                  rd_zero;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.word;
    end
    rd_q     <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
    rd_zero  <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // untouched entries read as their reset contents
  assign rd_word = rd_valid ? rd_q :
                   (rd_zero ? rrtt_pkg::SLOT0_RESET : rrtt_pkg::SLOTN_RESET);

endmodule

`default_nettype wire

>>> hw/rtl/round_robin_thread_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Round-robin thread table: one command word in (create, terminate by id, block
// current, unblock by id, timer tick), one result word out. Slot state and owner
// ids live in a single-port-read slot store with registered read data, scanned one
// slot per cycle. Block and unused commands go straight from reading the current slot
// to the write step; create, terminate, unblock and tick scan until a hit or until all
// SLOT_COUNT slots are examined, and a tick that switches adds a fix-up step that
// returns the old running slot to ready. A result waits in an output register and the
// next command is taken once it has been loaded there. Reset is immediate; there is no
// clearing pass.
module round_robin_thread_table_core (
  input wire logic   clk,
  input wire logic   rst,
  rrtt_cmd_if.sink   cmd,
  rrtt_res_if.source res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_SCAN,
    S_EXEC,
    S_FIX,
    S_DONE
  } state_t;

  localparam logic [rrtt_pkg::LIVE_W-1:0] LIVE_W_ONE = rrtt_pkg::LIVE_W'(1);

  state_t                                state;
  logic [rrtt_pkg::MODE_W-1:0]           mode;
  logic [rrtt_pkg::ID_W-1:0]             target_id;
  logic [rrtt_pkg::SLOT_W-1:0]           cur;
  logic [rrtt_pkg::ID_W-1:0]             id_counter;
  logic [rrtt_pkg::LIVE_W-1:0]           live_count;
  rrtt_pkg::slot_word_t                  cur_word;
  rrtt_pkg::slot_word_t                  found_word;
  logic                                  found;
  logic [rrtt_pkg::SLOT_W-1:0]           found_addr;
  logic [rrtt_pkg::SLOT_W-1:0]           chk_addr;
  logic [rrtt_pkg::SLOT_W-1:0]           cnt;
  logic [rrtt_pkg::STATUS_W-1:0]         r_status;
  logic [rrtt_pkg::ID_W-1:0]             r_new_id;
  logic                                  r_switched;
  logic                                  res_valid;

  logic [rrtt_pkg::SLOT_W-1:0]           rd_addr;
  rrtt_pkg::slot_word_t                  rd_word;
  rrtt_pkg::slot_wr_t                    wr;
  logic                                  hit;
  logic                                  scan_mode;
  logic                                  tick_switch;
  logic                                  accept;
  logic [rrtt_pkg::SLOT_W-1:0]           start_addr;

  rrtt_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_word (rd_word),
    .wr      (wr)
  );

  assign cmd.ready = (state == S_IDLE) && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign res.valid = res_valid;

  assign scan_mode = (mode == rrtt_pkg::MODE_CREATE) || (mode == rrtt_pkg::MODE_TERMINATE) ||
                     (mode == rrtt_pkg::MODE_UNBLOCK) || (mode == rrtt_pkg::MODE_TICK);
  assign start_addr  = (mode == rrtt_pkg::MODE_TICK) ? rrtt_pkg::next_slot(cur) : '0;
  assign tick_switch = (mode == rrtt_pkg::MODE_TICK) && found && (found_addr != cur);

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = cur;
      S_CUR:   rd_addr = start_addr;
      S_SCAN:  rd_addr = rrtt_pkg::next_slot(chk_addr);
      default: rd_addr = cur;
    endcase
  end

  always_comb begin
    case (mode)
      rrtt_pkg::MODE_CREATE:
        hit = (rd_word.state == rrtt_pkg::SLOT_FREE);
      rrtt_pkg::MODE_TERMINATE:
        hit = (rd_word.state != rrtt_pkg::SLOT_FREE) && (rd_word.id == target_id);
      rrtt_pkg::MODE_UNBLOCK:
        hit = (rd_word.state == rrtt_pkg::SLOT_BLOCKED) && (rd_word.id == target_id);
      rrtt_pkg::MODE_TICK:
        hit = (rd_word.state == rrtt_pkg::SLOT_READY);
      default:
        hit = 1'b0;
    endcase
  end

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = found_addr;
    wr.word = '{state: rrtt_pkg::SLOT_READY, id: found_word.id};
    if (state == S_EXEC) begin
      case (mode)
        rrtt_pkg::MODE_CREATE: begin
          wr.en   = found;
          wr.word = '{state: rrtt_pkg::SLOT_READY, id: id_counter};
        end
        rrtt_pkg::MODE_TERMINATE: begin
          wr.en   = found;
          wr.word = '{state: rrtt_pkg::SLOT_FREE, id: found_word.id};
        end
        rrtt_pkg::MODE_BLOCK: begin
          wr.en   = (cur_word.state == rrtt_pkg::SLOT_READY) ||
                    (cur_word.state == rrtt_pkg::SLOT_RUNNING);
          wr.addr = cur;
          wr.word = '{state: rrtt_pkg::SLOT_BLOCKED, id: cur_word.id};
        end
        rrtt_pkg::MODE_UNBLOCK: begin
          wr.en   = found;
        end
        rrtt_pkg::MODE_TICK: begin
          wr.en   = tick_switch;
          wr.word = '{state: rrtt_pkg::SLOT_RUNNING, id: found_word.id};
        end
        default: begin
          wr.en   = 1'b0;
        end
      endcase
    end else if (state == S_FIX) begin
      // only a running thread goes back to ready
      wr.en   = (cur_word.state == rrtt_pkg::SLOT_RUNNING);
      wr.addr = cur;
      wr.word = '{state: rrtt_pkg::SLOT_READY, id: cur_word.id};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur        <= '0;
      id_counter <= rrtt_pkg::ID_NEXT;
      live_count <= LIVE_W_ONE;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode      <= cmd.mode;
            target_id <= cmd.target_id;
            state     <= S_CUR;
          end
        end
        S_CUR: begin
          cur_word <= rd_word;
          found    <= 1'b0;
          cnt      <= '0;
          chk_addr <= start_addr;
          state    <= scan_mode ? S_SCAN : S_EXEC;
        end
        S_SCAN: begin
          if (hit) begin
            found      <= 1'b1;
            found_addr <= chk_addr;
            found_word <= rd_word;
            state      <= S_EXEC;
          end else if (cnt == rrtt_pkg::SLOT_W'(rrtt_pkg::SLOT_COUNT - 1)) begin
            state <= S_EXEC;
          end else begin
            chk_addr <= rrtt_pkg::next_slot(chk_addr);
            cnt      <= cnt + 1'b1;
          end
        end
        S_EXEC: begin
          r_status   <= rrtt_pkg::STATUS_OK;
          r_new_id   <= '0;
          r_switched <= tick_switch;
          case (mode)
            rrtt_pkg::MODE_CREATE: begin
              if (found) begin
                r_new_id   <= id_counter;
                id_counter <= id_counter + 1'b1;
                live_count <= live_count + 1'b1;
              end else begin
                r_status <= rrtt_pkg::STATUS_FULL;
              end
            end
            rrtt_pkg::MODE_TERMINATE: begin
              if (found) begin
                if (live_count != '0) begin
                  live_count <= live_count - 1'b1;
                end
              end else begin
                r_status <= rrtt_pkg::STATUS_NOT_FOUND;
              end
            end
            rrtt_pkg::MODE_UNBLOCK: begin
              if (!found) begin
                r_status <= rrtt_pkg::STATUS_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
          state <= tick_switch ? S_FIX : S_DONE;
        end
        S_FIX: begin
          cur   <= found_addr;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res.status       <= r_status;
            res.new_id       <= r_new_id;
            res.running_slot <= rrtt_pkg::SLOT_FIELD_W'(cur);
            res.switched     <= r_switched;
            res.live_threads <= rrtt_pkg::LIVE_FIELD_W'(live_count);
            res_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rrtt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rrtt_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 cmd_valid,
  input wire logic                                 cmd_ready,
  input wire logic                                 res_valid,
  input wire logic                                 res_ready,
  input wire logic [rrtt_pkg::STATUS_W-1:0]        res_status,
  input wire logic [rrtt_pkg::ID_W-1:0]            res_new_id,
  input wire logic [rrtt_pkg::SLOT_FIELD_W-1:0]    res_running_slot,
  input wire logic                                 res_switched,
  input wire logic [rrtt_pkg::LIVE_FIELD_W-1:0]    res_live_threads
);

  // one command in flight: accept drops ready for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted while previous one in progress");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_status) &&
      $stable(res_new_id) && $stable(res_running_slot) && $stable(res_switched) &&
      $stable(res_live_threads)))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_status == rrtt_pkg::STATUS_OK ||
                   res_status == rrtt_pkg::STATUS_FULL ||
                   res_status == rrtt_pkg::STATUS_NOT_FOUND))
    else $error("undefined status code");

  a_error_no_effect: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != rrtt_pkg::STATUS_OK) |->
      (res_new_id == '0 && !res_switched))
    else $error("failed command reported an id or a switch");

endmodule

bind round_robin_thread_table_core rrtt_checker u_rrtt_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_status       (res.status),
  .res_new_id       (res.new_id),
  .res_running_slot (res.running_slot),
  .res_switched     (res.switched),
  .res_live_threads (res.live_threads)
);

`default_nettype wire
